// ----- hw/rtl/pn3_pkg.sv -----
// ----------------------------------------------------------------------------
// pn3_pkg
// Shared constants and permutation ROM for 3D gradient noise.
// ----------------------------------------------------------------------------
package pn3_pkg;

  localparam int unsigned CELL_W = 8;

  typedef logic [CELL_W-1:0] cell_t;

  function automatic cell_t perm(input cell_t i);
    cell_t r;
    case (i)
      8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
      8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
      8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
      8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
      8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
      8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
      8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
      8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
      8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
      8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
      8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
      8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
      8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
      8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
      8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
      8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
      8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
      8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
      8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
      8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
      8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
      8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
      8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
      8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
      8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
      8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
      8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
      8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
      8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
      8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
      8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
      8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
      8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
      8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
      8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
      8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
      8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
      8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
      8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
      8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
      8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
      8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
      8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
      8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
      8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
      8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
      8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
      8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
      8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
      8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
      8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
      8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
      8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
      8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
      8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
      8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
      8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
      8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
      8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
      8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
      8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
      8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
      8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
      8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/pn3_fade.sv -----
// ----------------------------------------------------------------------------
// pn3_fade
// Pipelined quintic fade 6t^5-15t^4+10t^3, one multiply per stage.
// ----------------------------------------------------------------------------
module pn3_fade #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] f,
  output logic [FRAC_BITS+3:0] fade
);
  localparam int RW = FRAC_BITS + 4;
  localparam int PW = 2*FRAC_BITS + 4;
  localparam logic [RW-1:0] ONE = RW'(1) << FRAC_BITS;

  // f*q, q <= 15*ONE; then f*r with r <= 10*ONE
  logic [FRAC_BITS-1:0] f1, f2, f3;
  logic [RW-1:0]        r1, r2, r3;
  logic [PW-1:0]        p1, p2, p3, p4;

  assign p1 = PW'(f) * PW'(RW'(15) * ONE - RW'(6) * RW'(f));
  assign p2 = PW'(f1) * PW'(r1);
  assign p3 = PW'(f2) * PW'(r2);
  assign p4 = PW'(f3) * PW'(r3);

  always_ff @(posedge clk) begin
    if (en) begin
      f1   <= f;
      r1   <= RW'(10) * ONE - RW'(p1 >> FRAC_BITS);
      f2   <= f1;
      r2   <= RW'(p2 >> FRAC_BITS);
      f3   <= f2;
      r3   <= RW'(p3 >> FRAC_BITS);
      fade <= RW'(p4 >> FRAC_BITS);
    end
  end
endmodule

// ----- hw/rtl/pn3_lerp.sv -----
// ----------------------------------------------------------------------------
// pn3_lerp
// Registered blend a + floor(t*(b-a) / ONE).
// ----------------------------------------------------------------------------
module pn3_lerp #(
  parameter int FRAC_BITS = 16,
  parameter int VW = 20
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [FRAC_BITS+3:0]  t,
  input  logic signed [VW-1:0]  a,
  input  logic signed [VW-1:0]  b,
  output logic signed [VW-1:0]  y
);
  localparam int MW = VW + FRAC_BITS + 6;
  logic signed [MW-1:0] prod;
  assign prod = $signed({1'b0, (MW-1)'(t)}) * (MW'(b) - MW'(a));
  always_ff @(posedge clk) begin
    if (en) y <= a + VW'(prod >>> FRAC_BITS);
  end
endmodule

// ----- hw/rtl/perlin_noise_3d.sv -----
// ----------------------------------------------------------------------------
// perlin_noise_3d
// Improved 3D gradient noise, fully pipelined, one point per cycle unless stalled.
// ----------------------------------------------------------------------------
// Accepts one request per cycle unless stalled and returns one noise
// sample per request, in order, registered through every stage to the
// output register. The rate is one request per clock when not stalled,
// set by the pipeline: hashing takes three stages of permutation ROM
// lookups while the fade runs four chained multiply stages in parallel;
// gradient dot products take one stage, then the three blend levels one
// stage each, then saturation. A stall freezes the whole pipeline;
// upstream sees stall only when the output holds a finished sample that
// is not taken.
module perlin_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] noise_value
);
  localparam int FB = FRAC_BITS;
  localparam int TW = FB + 4;  // fade width
  localparam int VW = FB + 4;  // signed value width; dots within +/-2 ONE
  localparam int NST = 10;
  localparam logic signed [VW-1:0] ONE = VW'(1) << FB;

  typedef logic [7:0] c8_t;

  logic [NST-1:0] vld;
  logic en;
  // pipeline advances unless the last stage holds an untaken result
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: fields
  c8_t cx1, cy1, cz1;
  logic [FB-1:0] fx1, fy1, fz1;
  always_ff @(posedge clk) begin
    if (en) begin
      cx1 <= point_x[FB +: 8]; cy1 <= point_y[FB +: 8]; cz1 <= point_z[FB +: 8];
      fx1 <= point_x[FB-1:0]; fy1 <= point_y[FB-1:0]; fz1 <= point_z[FB-1:0];
    end
  end

  // stage 2: A, B
  c8_t a2, b2, cz2;
  logic [FB-1:0] fx2, fy2, fz2;
  always_ff @(posedge clk) begin
    if (en) begin
      a2 <= pn3_pkg::perm(cx1) + cy1;
      b2 <= pn3_pkg::perm(cx1 + 8'd1) + cy1;
      cz2 <= cz1; fx2 <= fx1; fy2 <= fy1; fz2 <= fz1;
    end
  end

  // stage 3: AA AB BA BB
  c8_t aa3, ab3, ba3, bb3;
  logic [FB-1:0] fx3, fy3, fz3;
  always_ff @(posedge clk) begin
    if (en) begin
      aa3 <= pn3_pkg::perm(a2) + cz2;
      ab3 <= pn3_pkg::perm(a2 + 8'd1) + cz2;
      ba3 <= pn3_pkg::perm(b2) + cz2;
      bb3 <= pn3_pkg::perm(b2 + 8'd1) + cz2;
      fx3 <= fx2; fy3 <= fy2; fz3 <= fz2;
    end
  end

  // stage 4: corner hashes, order: aa ba ab bb aa1 ba1 ab1 bb1
  logic [3:0] h4 [8];
  logic [FB-1:0] fx4, fy4, fz4;
  always_ff @(posedge clk) begin
    if (en) begin
      h4[0] <= 4'(pn3_pkg::perm(aa3));
      h4[1] <= 4'(pn3_pkg::perm(ba3));
      h4[2] <= 4'(pn3_pkg::perm(ab3));
      h4[3] <= 4'(pn3_pkg::perm(bb3));
      h4[4] <= 4'(pn3_pkg::perm(aa3 + 8'd1));
      h4[5] <= 4'(pn3_pkg::perm(ba3 + 8'd1));
      h4[6] <= 4'(pn3_pkg::perm(ab3 + 8'd1));
      h4[7] <= 4'(pn3_pkg::perm(bb3 + 8'd1));
      fx4 <= fx3; fy4 <= fy3; fz4 <= fz3;
    end
  end

  // fades: input at stage 1 regs, output valid at stage 5
  logic [TW-1:0] u5, v5, w5;
  pn3_fade #(.FRAC_BITS(FB)) u_fu (.clk, .en, .f(fx1), .fade(u5));
  pn3_fade #(.FRAC_BITS(FB)) u_fv (.clk, .en, .f(fy1), .fade(v5));
  pn3_fade #(.FRAC_BITS(FB)) u_fw (.clk, .en, .f(fz1), .fade(w5));

  // stage 5: gradient dot products
  logic signed [VW-1:0] g5 [8];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        logic signed [VW-1:0] gx, gy, gz, gu, gv;
        logic [3:0] h;
        h  = h4[k];
        gx = $signed(VW'(fx4)) - ((k % 2 == 1) ? ONE : '0);
        gy = $signed(VW'(fy4)) - (((k / 2) % 2 == 1) ? ONE : '0);
        gz = $signed(VW'(fz4)) - ((k >= 4) ? ONE : '0);
        gu = (h < 4'd8) ? gx : gy;
        gv = (h < 4'd4) ? gy : ((h == 4'd12 || h == 4'd14) ? gx : gz);
        g5[k] <= (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
      end
    end
  end

  // blend levels: stage 6 (u), 7 (v), 8 (w)
  logic [TW-1:0] v6, w6, w7;
  always_ff @(posedge clk) begin
    if (en) begin
      v6 <= v5; w6 <= w5; w7 <= w6;
    end
  end

  logic signed [VW-1:0] l6 [4];
  logic signed [VW-1:0] l7 [2];
  logic signed [VW-1:0] r8;
  for (genvar k = 0; k < 4; k++) begin : g_lu
    pn3_lerp #(.FRAC_BITS(FB), .VW(VW)) u_l (.clk, .en, .t(u5),
      .a(g5[2*k]), .b(g5[2*k+1]), .y(l6[k]));
  end
  for (genvar k = 0; k < 2; k++) begin : g_lv
    pn3_lerp #(.FRAC_BITS(FB), .VW(VW)) u_l (.clk, .en, .t(v6),
      .a(l6[2*k]), .b(l6[2*k+1]), .y(l7[k]));
  end
  pn3_lerp #(.FRAC_BITS(FB), .VW(VW)) u_lw (.clk, .en, .t(w7),
    .a(l7[0]), .b(l7[1]), .y(r8));

  // stage 9..10: saturation to 18 bits, output register
  localparam int SW = (VW > 18) ? VW : 18;
  logic signed [SW-1:0] rx;
  assign rx = SW'(r8);
  logic signed [17:0] sat9;
  always_ff @(posedge clk) begin
    if (en) begin
      if (rx > SW'(131071)) sat9 <= 18'sd131071;
      else if (rx < -SW'(131072)) sat9 <= -18'sd131072;
      else sat9 <= 18'(rx);
      noise_value <= sat9;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end
  assign out_valid = vld[NST-1];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(noise_value)))
    else $error("result lost under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without cause");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (en && !rst) |=> (vld[0] == $past(in_valid)))
    else $error("valid bit not tracking input");
endmodule
